// ===== sv/sorted_quartile_split_macros.svh =====
// assertion macros shared by the quartile split modules
`ifndef SORTED_QUARTILE_SPLIT_MACROS_SVH
`define SORTED_QUARTILE_SPLIT_MACROS_SVH

// expression holds at every clock edge out of reset
`define SQS_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define SQS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define SQS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sqs_pkg.sv =====
// shared constants and types for the quartile split block
`default_nettype none

package sqs_pkg;

    localparam int CAPACITY   = 128;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int AGE_W      = 8;
    localparam int COUNT_W    = 8;
    localparam int GROUP_W    = 2;
    localparam int NUM_GROUPS = 4;

    localparam logic [GROUP_W-1:0] LAST_GROUP = GROUP_W'(NUM_GROUPS - 1);

    typedef logic [AGE_W-1:0] age_t;

    // one write and one read address toward the age store
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        age_t              wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

endpackage

`default_nettype wire

// ===== sv/sqs_age_ram.sv =====
// simple dual-port ram with registered read data
`default_nettype none

module sqs_age_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/sqs_sorter.sv =====
// insertion sort sequencer over the age store, one compare unit
`default_nettype none
`include "sorted_quartile_split_macros.svh"

module sqs_sorter
    import sqs_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [CNT_W-1:0] n,
    input  wire age_t             rdata,
    output ram_req_t              req,
    output logic                  done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_GET_V,
        S_CMP,
        S_PLACE
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [CNT_W-1:0]  i_reg;
    logic [ADDR_W-1:0] j_reg;
    age_t              v_reg;
    logic              done_reg;

    logic [CNT_W-1:0]  i_plus;
    logic              greater;
    logic              i_end;

    assign i_plus  = i_reg + CNT_W'(1);
    assign i_end   = (i_plus == n_reg);
    // the shared comparator
    assign greater = (rdata > v_reg);
    assign done    = done_reg;

    always_comb
    begin
        req = '0;
        unique case (state_reg)
            S_IDLE:
            begin
            end
            S_START:
            begin
                req.raddr = i_reg[ADDR_W-1:0];
            end
            S_GET_V:
            begin
                req.raddr = ADDR_W'(i_reg - CNT_W'(1));
            end
            S_CMP:
            begin
                req.we    = 1'b1;
                req.waddr = j_reg;
                if (greater)
                begin
                    req.wdata = rdata;
                    req.raddr = ADDR_W'(j_reg - ADDR_W'(2));
                end
                else
                begin
                    req.wdata = v_reg;
                    req.raddr = i_plus[ADDR_W-1:0];
                end
            end
            S_PLACE:
            begin
                req.we    = 1'b1;
                req.waddr = '0;
                req.wdata = v_reg;
                req.raddr = i_plus[ADDR_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            n_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            v_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        n_reg <= n;
                        i_reg <= CNT_W'(1);
                        if (n <= CNT_W'(1))
                        begin
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_START;
                        end
                    end
                end
                S_START:
                begin
                    state_reg <= S_GET_V;
                end
                S_GET_V:
                begin
                    v_reg     <= rdata;
                    j_reg     <= i_reg[ADDR_W-1:0];
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (greater)
                    begin
                        // shift one entry up and keep walking down
                        j_reg <= j_reg - ADDR_W'(1);
                        if (j_reg == ADDR_W'(1))
                        begin
                            state_reg <= S_PLACE;
                        end
                    end
                    else
                    begin
                        i_reg <= i_plus;
                        if (i_end)
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_GET_V;
                        end
                    end
                end
                S_PLACE:
                begin
                    i_reg <= i_plus;
                    if (i_end)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_GET_V;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `SQS_ASSERT_IMPL(a_done_idle, done_reg, state_reg == S_IDLE, "done outside idle")
    `SQS_ASSERT_IMPL(a_cmp_j, state_reg == S_CMP, j_reg != '0, "compare at entry zero")
    `SQS_ASSERT_IMPL(a_i_range, state_reg != S_IDLE, i_reg < n_reg, "outer index past set size")

endmodule

`default_nettype wire

// ===== sv/sorted_quartile_split.sv =====
// top level: age loader, sort control and quartile group readout
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------------
//  input    | in_valid / in_stall  | age, has_value, is_last
//  output   | out_valid / out_stall| group, count, min_age, max_age, empty_set,
//           |                      | last_of_run
//
// ages load one per cycle into a 128-entry ram, in_stall stays low while loading
// the last request of a non-empty set starts an insertion sort of the loaded ages
// in the ram, run by the sorter, which owns the ram port until it is done
// readout then walks the 4 groups: two ram reads (first and last entry), then emit
// an empty set skips sort and reads and goes straight to emit to raise out_valid
// reset clears all registers but the age store, which needs no clearing
// out_stall holds the current result in the output register and pauses readout
`default_nettype none
`include "sorted_quartile_split_macros.svh"

module sorted_quartile_split
    import sqs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [AGE_W-1:0]   age,
    input  wire logic               has_value,
    input  wire logic               is_last,

    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [GROUP_W-1:0]      group,
    output logic [COUNT_W-1:0]      count,
    output logic [AGE_W-1:0]        min_age,
    output logic [AGE_W-1:0]        max_age,
    output logic                    empty_set,
    output logic                    last_of_run
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_SORT,
        S_GRP_A,
        S_GRP_B,
        S_GRP_C,
        S_EMIT
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   loaded_reg;
    logic [CNT_W-1:0]   n_reg;
    logic [GROUP_W-1:0] grp_reg;
    logic [CNT_W-1:0]   base_reg;
    age_t               min_reg;
    age_t               max_reg;
    logic               empty_reg;

    // output register
    logic               out_valid_reg;
    logic [GROUP_W-1:0] group_reg;
    logic [COUNT_W-1:0] count_reg;
    age_t               min_age_reg;
    age_t               max_age_reg;
    logic               empty_set_reg;
    logic               last_reg;

    logic               in_accept;
    logic               do_write;
    logic [CNT_W-1:0]   n_next;
    logic [CNT_W-1:0]   quart;
    logic [CNT_W-1:0]   grp_size;
    logic [ADDR_W-1:0]  last_addr;
    logic               out_free;
    logic               grp_final;

    ram_req_t           top_req;
    ram_req_t           sort_req;
    ram_req_t           ram_req;
    age_t               rdata;
    logic               sort_start;
    logic               sort_done;

    assign in_stall  = (state_reg != S_LOAD);
    assign in_accept = in_valid && !in_stall;
    // ages beyond capacity are dropped
    assign do_write  = in_accept && has_value && (loaded_reg < CNT_W'(CAPACITY));
    assign n_next    = loaded_reg + CNT_W'(do_write);
    assign sort_start = in_accept && is_last && (n_next != '0);

    // group size: n/4, plus one for the first n mod 4 groups
    assign quart     = n_reg >> 2;
    assign grp_size  = quart + CNT_W'(CNT_W'(grp_reg) < CNT_W'(n_reg[1:0]));
    assign last_addr = ADDR_W'(base_reg + grp_size - CNT_W'(1));
    assign out_free  = !out_valid_reg || !out_stall;
    assign grp_final = empty_reg || (grp_reg == LAST_GROUP);

    always_comb
    begin
        top_req = '0;
        unique case (state_reg)
            S_LOAD:
            begin
                top_req.we    = do_write;
                top_req.waddr = loaded_reg[ADDR_W-1:0];
                top_req.wdata = age;
            end
            S_GRP_A:
            begin
                top_req.raddr = base_reg[ADDR_W-1:0];
            end
            S_GRP_B:
            begin
                top_req.raddr = last_addr;
            end
            S_SORT, S_GRP_C, S_EMIT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // the sorter owns the ram port while it runs
    assign ram_req = (state_reg == S_SORT) ? sort_req : top_req;

    sqs_age_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (AGE_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (rdata)
    );

    sqs_sorter u_sorter (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sort_start),
        .n     (n_next),
        .rdata (rdata),
        .req   (sort_req),
        .done  (sort_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            loaded_reg    <= '0;
            n_reg         <= '0;
            grp_reg       <= '0;
            base_reg      <= '0;
            min_reg       <= '0;
            max_reg       <= '0;
            empty_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            group_reg     <= '0;
            count_reg     <= '0;
            min_age_reg   <= '0;
            max_age_reg   <= '0;
            empty_set_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_LOAD:
                begin
                    if (in_accept)
                    begin
                        if (is_last)
                        begin
                            loaded_reg <= '0;
                            n_reg      <= n_next;
                            grp_reg    <= '0;
                            base_reg   <= '0;
                            min_reg    <= '0;
                            max_reg    <= '0;
                            empty_reg  <= (n_next == '0);
                            // empty set goes straight to its single result
                            state_reg  <= (n_next == '0) ? S_EMIT : S_SORT;
                        end
                        else
                        begin
                            loaded_reg <= n_next;
                        end
                    end
                end
                S_SORT:
                begin
                    if (sort_done)
                    begin
                        state_reg <= S_GRP_A;
                    end
                end
                S_GRP_A:
                begin
                    // first ram read issued here, skip reads for an empty group
                    if (grp_size == '0)
                    begin
                        min_reg   <= '0;
                        max_reg   <= '0;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_GRP_B;
                    end
                end
                S_GRP_B:
                begin
                    min_reg   <= rdata;
                    state_reg <= S_GRP_C;
                end
                S_GRP_C:
                begin
                    max_reg   <= rdata;
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        group_reg     <= grp_reg;
                        count_reg     <= COUNT_W'(grp_size);
                        min_age_reg   <= min_reg;
                        max_age_reg   <= max_reg;
                        empty_set_reg <= empty_reg;
                        last_reg      <= grp_final;
                        if (grp_final)
                        begin
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            grp_reg   <= grp_reg + GROUP_W'(1);
                            base_reg  <= base_reg + grp_size;
                            state_reg <= S_GRP_A;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign group       = group_reg;
    assign count       = count_reg;
    assign min_age     = min_age_reg;
    assign max_age     = max_age_reg;
    assign empty_set   = empty_set_reg;
    assign last_of_run = last_reg;

    `SQS_ASSERT_ALWAYS(a_load_cap, loaded_reg <= CNT_W'(CAPACITY), "load count over capacity")
    `SQS_ASSERT_NEXT(a_last_leaves_load, in_accept && is_last, state_reg != S_LOAD,
        "last request did not start a run")
    `SQS_ASSERT_IMPL(a_empty_zero, out_valid_reg && empty_set_reg,
        count_reg == '0 && min_age_reg == '0 && max_age_reg == '0 && last_reg,
        "empty set result not cleared")
    `SQS_ASSERT_IMPL(a_last_group, out_valid_reg && last_reg && !empty_set_reg,
        group_reg == LAST_GROUP, "run ended before last group")
    `SQS_ASSERT_IMPL(a_minmax_order, out_valid_reg, min_age_reg <= max_age_reg,
        "group min above max")

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// testbench for sorted_quartile_split: directed table, random age sets, scoreboard check
`timescale 1ns / 100ps

module tb
    import sqs_pkg::*;
();

    localparam int IDLE_PCT     = 22;     // idle chance per cycle on either side
    localparam int RANDOM_ITEMS = 180;    // value and end requests in the random part
    localparam int HOLD_CYCLES  = 400;    // one long receiver hold-off
    localparam int HOLD_AFTER   = 30;     // results seen before the hold-off starts
    localparam int STALL_LIMIT  = 60000;  // watchdog limit, longer than a full 128-entry sort
    localparam int DRAIN_CYCLES = 40;
    localparam int DIR_ROWS     = 26;

    typedef struct packed {
        logic [GROUP_W-1:0] grp;
        logic [COUNT_W-1:0] cnt;
        age_t               lo;
        age_t               hi;
        logic               empty;
        logic               last;
    } group_result_t;

    // one directed request, with a literal expectation where it is obvious
    typedef struct packed {
        age_t          a;
        logic          hv;
        logic          lst;
        logic          typed;
        group_result_t fixed;
    } stim_row_t;

    localparam group_result_t EMPTY_SET = '{grp: '0, cnt: '0, lo: '0, hi: '0,
                                            empty: 1'b1, last: 1'b1};
    localparam group_result_t NO_FIXED  = '0;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [AGE_W-1:0]   age;
    logic               has_value;
    logic               is_last;
    logic               out_valid;
    logic               out_stall;
    logic [GROUP_W-1:0] group;
    logic [COUNT_W-1:0] count;
    logic [AGE_W-1:0]   min_age;
    logic [AGE_W-1:0]   max_age;
    logic               empty_set;
    logic               last_of_run;

    // predictor state: ages of the set being loaded, expected group results
    age_t          set_ages[$];
    group_result_t quartile_q[$];

    stim_row_t dir_tab [DIR_ROWS];

    int  errors;
    int  requests_sent;
    int  sets_closed;
    int  results_checked;
    int  largest_set;
    int  idle_cycles;
    logic calm;

    sorted_quartile_split uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .age         (age),
        .has_value   (has_value),
        .is_last     (is_last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .group       (group),
        .count       (count),
        .min_age     (min_age),
        .max_age     (max_age),
        .empty_set   (empty_set),
        .last_of_run (last_of_run)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // sort the loaded ages and, when publish is set, queue the four group results, or the empty-set result
    function automatic void split_quartiles(input logic publish);
        age_t          srt [CAPACITY];
        age_t          v;
        int            n;
        int            i;
        int            j;
        int            quart;
        int            rem;
        int            base;
        int            size;
        group_result_t r;
        n = set_ages.size();
        for (i = 0; i < n; i++)
            srt[i] = set_ages[i];
        for (i = 1; i < n; i++)
        begin
            v = srt[i];
            j = i;
            while (j > 0 && srt[j-1] > v)
            begin
                srt[j] = srt[j-1];
                j--;
            end
            srt[j] = v;
        end
        set_ages.delete();
        sets_closed++;
        if (n > largest_set)
            largest_set = n;
        if (!publish)
            return;
        if (n == 0)
        begin
            quartile_q.push_back(EMPTY_SET);
            return;
        end
        quart = n / NUM_GROUPS;
        rem   = n % NUM_GROUPS;
        base  = 0;
        for (i = 0; i < NUM_GROUPS; i++)
        begin
            size    = quart + ((i < rem) ? 1 : 0);
            r.grp   = GROUP_W'(i);
            r.cnt   = COUNT_W'(size);
            r.lo    = (size > 0) ? srt[base] : '0;
            r.hi    = (size > 0) ? srt[base + size - 1] : '0;
            r.empty = 1'b0;
            r.last  = (r.grp == LAST_GROUP);
            quartile_q.push_back(r);
            base += size;
        end
    endfunction

    // fold one accepted request into the predictor
    function automatic void track_request(input age_t a, input logic hv, input logic lst,
                                          input logic publish);
        if (hv && set_ages.size() < CAPACITY)
            set_ages.push_back(a);
        if (lst)
            split_quartiles(publish);
    endfunction

    // offer one request, with random idle cycles first, and wait for it to be taken
    task automatic send_request(input age_t a, input logic hv, input logic lst);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        age       <= a;
        has_value <= hv;
        is_last   <= lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        requests_sent++;
    endtask

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function automatic void check_result();
        group_result_t want;
        if (quartile_q.size() == 0)
        begin
            $error("unexpected result: group %0d count %0d min %0d max %0d",
                   group, count, min_age, max_age);
            errors++;
            return;
        end
        want = quartile_q.pop_front();
        compare_field("group",       want.grp,   group);
        compare_field("count",       want.cnt,   count);
        compare_field("min_age",     want.lo,    min_age);
        compare_field("max_age",     want.hi,    max_age);
        compare_field("empty_set",   want.empty, empty_set);
        compare_field("last_of_run", want.last,  last_of_run);
        results_checked++;
    endfunction

    // result side: random stall, one long hold-off once results are flowing
    initial
    begin : result_sink
        int   hold_left;
        logic held;
        hold_left = 0;
        held      = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                check_result();
            if (!held && results_checked >= HOLD_AFTER)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // watchdog: cycles in a row with no handshake on either channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("sorted_quartile_split test failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        int   i;
        int   k;
        int   n;
        int   set_idx;
        int   random_items;
        logic big_done;
        logic bare_end;
        logic narrow;
        logic lst;
        age_t a;
        age_t base;

        clk             = 1'b0;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        age             = '0;
        has_value       = 1'b0;
        is_last         = 1'b0;
        out_stall       = 1'b0;
        calm            = 1'b0;
        errors          = 0;
        requests_sent   = 0;
        sets_closed     = 0;
        results_checked = 0;
        largest_set     = 0;
        idle_cycles     = 0;

        // age, has_value, is_last, typed, literal expectation
        dir_tab = '{
            // bare end right after reset: the empty-set result
            '{8'd0,   1'b0, 1'b1, 1'b1, EMPTY_SET},
            // a marker without a value is not loaded, so the set stays empty
            '{8'hab,  1'b0, 1'b0, 1'b0, NO_FIXED},
            '{8'h54,  1'b0, 1'b1, 1'b1, EMPTY_SET},
            // one age carried on the last request, three empty groups
            '{8'd255, 1'b1, 1'b1, 1'b0, NO_FIXED},
            // both extremes of age
            '{8'd0,   1'b1, 1'b0, 1'b0, NO_FIXED},
            '{8'd255, 1'b1, 1'b1, 1'b0, NO_FIXED},
            // three ages, unsorted, one empty group
            '{8'd7,   1'b1, 1'b0, 1'b0, NO_FIXED},
            '{8'd3,   1'b1, 1'b0, 1'b0, NO_FIXED},
            '{8'd200, 1'b1, 1'b1, 1'b0, NO_FIXED},
            // four ages in descending order
            '{8'd9,   1'b1, 1'b0, 1'b0, NO_FIXED},
            '{8'd8,   1'b1, 1'b0, 1'b0, NO_FIXED},
            '{8'd7,   1'b1, 1'b0, 1'b0, NO_FIXED},
            '{8'd6,   1'b1, 1'b1, 1'b0, NO_FIXED},
            // duplicates, then a bare end marker closes the set
            '{8'd5,   1'b1, 1'b0, 1'b0, NO_FIXED},
            '{8'd5,   1'b1, 1'b0, 1'b0, NO_FIXED},
            '{8'd0,   1'b1, 1'b0, 1'b0, NO_FIXED},
            '{8'd255, 1'b1, 1'b0, 1'b0, NO_FIXED},
            '{8'd5,   1'b1, 1'b0, 1'b0, NO_FIXED},
            '{8'd0,   1'b0, 1'b1, 1'b0, NO_FIXED},
            // six ages with an ignored marker in the middle
            '{8'd128, 1'b1, 1'b0, 1'b0, NO_FIXED},
            '{8'd64,  1'b0, 1'b0, 1'b0, NO_FIXED},
            '{8'd127, 1'b1, 1'b0, 1'b0, NO_FIXED},
            '{8'd1,   1'b1, 1'b0, 1'b0, NO_FIXED},
            '{8'd254, 1'b1, 1'b0, 1'b0, NO_FIXED},
            '{8'd128, 1'b1, 1'b0, 1'b0, NO_FIXED},
            '{8'd99,  1'b1, 1'b1, 1'b0, NO_FIXED}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIR_ROWS; i++)
        begin
            send_request(dir_tab[i].a, dir_tab[i].hv, dir_tab[i].lst);
            track_request(dir_tab[i].a, dir_tab[i].hv, dir_tab[i].lst, !dir_tab[i].typed);
            if (dir_tab[i].typed)
                quartile_q.push_back(dir_tab[i].fixed);
        end

        // random sets: mostly small, a few medium, one at or over capacity
        random_items = 0;
        set_idx      = 0;
        big_done     = 1'b0;
        while (random_items < RANDOM_ITEMS)
        begin
            if (set_idx == 3)
                calm <= 1'b1;
            else if (set_idx == 7)
                calm <= 1'b0;
            if (set_idx == 4 && !big_done)
            begin
                n        = CAPACITY + $urandom_range(0, 4);
                big_done = 1'b1;
            end
            else if ($urandom_range(9) == 0)
                n = $urandom_range(14, 40);
            else
                n = $urandom_range(0, 13);
            bare_end = (n == 0) || ($urandom_range(99) < 30);
            narrow   = 1'($urandom_range(1));
            base     = age_t'($urandom);
            for (k = 0; k < n; k++)
            begin
                // stray marker inside the set, age bits are don't-care
                if ($urandom_range(9) == 0)
                begin
                    a = age_t'($urandom);
                    send_request(a, 1'b0, 1'b0);
                    track_request(a, 1'b0, 1'b0, 1'b1);
                end
                a   = narrow ? base + age_t'($urandom_range(3)) : age_t'($urandom);
                lst = !bare_end && (k == n - 1);
                send_request(a, 1'b1, lst);
                track_request(a, 1'b1, lst, 1'b1);
                random_items++;
            end
            if (bare_end)
            begin
                a = age_t'($urandom);
                send_request(a, 1'b0, 1'b1);
                track_request(a, 1'b0, 1'b1, 1'b1);
                random_items++;
            end
            set_idx++;
        end
        in_valid <= 1'b0;

        while (quartile_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d requests in %0d sets, largest set %0d ages (capacity %0d)",
                 requests_sent, sets_closed, largest_set, CAPACITY);
        $display("%0d group results checked, %0d mismatches", results_checked, errors);
        if (errors == 0)
            $display("sorted_quartile_split test passed");
        else
            $display("sorted_quartile_split test failed");
        $finish;
    end

endmodule
